@@ rtl/crc32_framed_record_checker_assert.svh @@
// assertion macros for the framed record checker
`ifndef CRC32_FRAMED_RECORD_CHECKER_ASSERT_SVH
`define CRC32_FRAMED_RECORD_CHECKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define CFRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition must never be seen outside reset
`define CFRC_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define CFRC_ASSERT(lbl, prop, msg)
`define CFRC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ rtl/crcfrc_pkg.sv @@
// shared types and constants of the framed record checker
`timescale 1ns / 1ps
package crcfrc_pkg;

	localparam int POS_W = 13;

	localparam logic [31:0] MAGIC_CURRENT = 32'h3652_5543;
	localparam logic [31:0] MAGIC_PRESET  = 32'h3645_5250;
	localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
	localparam logic [POS_W-1:0] HEADER_BYTES = 13'd8;

	typedef enum logic [1:0] {
		CFG_RECORD_KIND    = 2'd0,
		CFG_SCHEMA_VERSION = 2'd1,
		CFG_PAYLOAD_SIZE   = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		REG_HEADER  = 2'd0,
		REG_NAME    = 2'd1,
		REG_PAYLOAD = 2'd2,
		REG_CRC     = 2'd3
	} region_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_MAGIC   = 3'd1,
		ERR_VERSION = 3'd2,
		ERR_KIND    = 3'd3,
		ERR_LENGTH  = 3'd4,
		ERR_NAME    = 3'd5,
		ERR_CRC     = 3'd6
	} err_t;

	typedef struct packed {
		logic             record_kind;
		logic [7:0]       schema_version;
		logic [POS_W-1:0] payload_size;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		region_t    region;
		logic       record_done;
		logic       record_ok;
		err_t       error_code;
	} res_t;

endpackage

@@ rtl/crcfrc_cfg_regs.sv @@
// configuration register file of the framed record checker
`timescale 1ns / 1ps
module crcfrc_cfg_regs
	import crcfrc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [POS_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.record_kind    <= 1'b0;
			cfg_q.schema_version <= 8'd6;
			cfg_q.payload_size   <= 13'd36;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_RECORD_KIND:    cfg_q.record_kind    <= cfg_data[0];
				CFG_SCHEMA_VERSION: cfg_q.schema_version <= cfg_data[7:0];
				CFG_PAYLOAD_SIZE:   cfg_q.payload_size   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/crcfrc_check.sv @@
// per-byte record check: position, running crc, first error and verdict
`timescale 1ns / 1ps
module crcfrc_check
	import crcfrc_pkg::*;
#(
	parameter int NAME_BYTES        = 16,
	parameter int MAX_PAYLOAD_BYTES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       step,
	input  logic [7:0] in_byte,
	input  logic       in_start,
	output res_t       res
);

	localparam logic [POS_W-1:0] NAME_LEN = POS_W'(NAME_BYTES);
	localparam logic [POS_W-1:0] MAX_PAY  = POS_W'(MAX_PAYLOAD_BYTES);

	logic [POS_W-1:0] pos_q;
	logic [31:0]      crc_q;
	err_t             ferr_q;
	logic [7:0]       hlen_q;

	logic [POS_W-1:0] pay, name_len, last_pos, trl_start, pos_raw, pos;
	logic [31:0]      crc_cur, crc_nxt, fin;
	err_t             ferr_cur, hit, err_nxt;
	logic             done;
	region_t          region;
	logic [7:0]       magic_b, crc_b;
	logic [1:0]       k;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic name_char_ok(input logic [7:0] c);
		return c == 8'h20 || c == 8'h2D || c == 8'h5F ||
		       (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39);
	endfunction

	always_comb begin
		// clamp payload size into 1 .. max
		if (cfg.payload_size == '0)
			pay = POS_W'(1);
		else if (cfg.payload_size > MAX_PAY)
			pay = MAX_PAY;
		else
			pay = cfg.payload_size;
		name_len  = cfg.record_kind ? NAME_LEN : '0;
		last_pos  = HEADER_BYTES + name_len + pay + POS_W'(3);
		trl_start = last_pos - POS_W'(3);

		// start marker clears the record state before the byte is used
		pos_raw  = in_start ? '0 : pos_q;
		crc_cur  = in_start ? CRC_INIT : crc_q;
		ferr_cur = in_start ? ERR_NONE : ferr_q;

		done = pos_raw >= last_pos;
		pos  = done ? last_pos : pos_raw;

		if (pos < HEADER_BYTES)
			region = REG_HEADER;
		else if (pos < HEADER_BYTES + name_len)
			region = REG_NAME;
		else if (pos < trl_start)
			region = REG_PAYLOAD;
		else
			region = REG_CRC;

		magic_b = 8'((cfg.record_kind ? MAGIC_PRESET : MAGIC_CURRENT) >> {pos[1:0], 3'b000});
		fin     = crc_cur ^ CRC_INIT;
		k       = pos[1:0] - trl_start[1:0];
		crc_b   = 8'(fin >> {k, 3'b000});

		hit = ERR_NONE;
		unique case (region)
			REG_HEADER: begin
				if (pos < POS_W'(4)) begin
					if (in_byte != magic_b) hit = ERR_MAGIC;
				end else if (pos == POS_W'(4)) begin
					if (in_byte != cfg.schema_version) hit = ERR_VERSION;
				end else if (pos == POS_W'(5)) begin
					if (cfg.record_kind && in_byte != 8'd1) hit = ERR_KIND;
				end else if (pos == POS_W'(7)) begin
					if ({in_byte, hlen_q} != {3'd0, pay}) hit = ERR_LENGTH;
				end
			end
			REG_NAME: begin
				if (!name_char_ok(in_byte)) hit = ERR_NAME;
			end
			REG_PAYLOAD: ;
			REG_CRC: begin
				if (in_byte != crc_b) hit = ERR_CRC;
			end
		endcase

		err_nxt = (ferr_cur != ERR_NONE) ? ferr_cur : hit;
		crc_nxt = (region != REG_CRC) ? crc_byte(crc_cur, in_byte) : crc_cur;

		res.out_byte    = in_byte;
		res.region      = region;
		res.record_done = done;
		res.error_code  = done ? err_nxt : ERR_NONE;
		res.record_ok   = done && (err_nxt == ERR_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			crc_q  <= CRC_INIT;
			ferr_q <= ERR_NONE;
			hlen_q <= '0;
		end else if (step) begin
			if (region == REG_HEADER && pos == POS_W'(6))
				hlen_q <= in_byte;
			if (done) begin
				pos_q  <= '0;
				crc_q  <= CRC_INIT;
				ferr_q <= ERR_NONE;
			end else begin
				pos_q  <= pos + POS_W'(1);
				crc_q  <= crc_nxt;
				ferr_q <= err_nxt;
			end
		end
	end

endmodule

@@ rtl/crc32_framed_record_checker.sv @@
// top level of the crc-32 framed record checker
`timescale 1ns / 1ps
// Framed record checker: takes one stored record byte per request on the s_ stream
// (s_tuser high marks the first byte of a record and forces position 0) and returns
// one request per byte on the m_ stream, echoing the byte with its region (header,
// name, payload, crc trailer). A record is a 4-byte little-endian magic, version,
// kind, 16-bit length, a NAME_BYTES name for preset records only, the payload and a
// reflected crc-32 over all bytes before the trailer. On the last byte m_tlast is
// high and m_tdata carries the pass flag and the first error found. Throughput is
// one byte per clock unless m_tready stalls: the byte-wide crc update, position
// compare and header checks all sit in one stage between the input register and
// the result register, and the next byte may follow in the next cycle. The user
// must write configuration through the cfg_ port only while idle (not enforced).
`include "crc32_framed_record_checker_assert.svh"
module crc32_framed_record_checker
	import crcfrc_pkg::*;
#(
	parameter int NAME_BYTES        = 16,
	parameter int MAX_PAYLOAD_BYTES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [POS_W-1:0] cfg_data,
	// record bytes in
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] record_byte
	input  logic             s_tuser,   // [0] record_start
	// checked bytes out
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,   // [7:0] out_byte, [8] record_ok, [11:9] error_code
	output logic [1:0]       m_tuser,   // [1:0] region
	output logic             m_tlast    // record_done
);

	cfg_t       cfg;
	res_t       res;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       valid_s2;
	res_t       res_s2;
	logic       adv;

	crcfrc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage 1 item moves into the result register when that register is empty or being read out
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	crcfrc_check #(
		.NAME_BYTES        (NAME_BYTES),
		.MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
	) u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.step     (adv),
		.in_byte  (byte_s1),
		.in_start (start_s1),
		.res      (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, res_s2.error_code, res_s2.record_ok, res_s2.out_byte};
	assign m_tuser  = res_s2.region;
	assign m_tlast  = res_s2.record_done;

	// verdict fields stay clear away from the last byte
	`CFRC_ASSERT_NEVER(a_verdict_only_last, m_tvalid && !m_tlast && (m_tdata[8] || m_tdata[11:9] != ERR_NONE), "verdict outside last byte")
	// pass flag agrees with the error code on the last byte
	`CFRC_ASSERT(a_ok_matches_code, m_tvalid && m_tlast |-> (m_tdata[8] == (m_tdata[11:9] == ERR_NONE)), "pass flag and error code disagree")
	// last byte always falls in the crc trailer
	`CFRC_ASSERT(a_last_in_trailer, m_tvalid && m_tlast |-> m_tuser == REG_CRC, "last byte outside trailer")
	// an empty result register never blocks the input
	`CFRC_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")

endmodule

@@ verif/crc32_framed_record_checker_tb.sv @@
// self-checking testbench for the crc-32 framed record checker
`timescale 1ns / 1ps
module crc32_framed_record_checker_tb;
	import crcfrc_pkg::*;

	localparam int NAME_LEN     = 16;
	localparam int PAYLOAD_CAP  = 4096;
	localparam int STALL_PCT    = 27;
	localparam int WATCHDOG_MAX = 2000;
	// legal name characters of a preset record
	localparam string NAME_CHARS = " -_ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [1:0]       cfg_index = CFG_RECORD_KIND;
	logic [POS_W-1:0] cfg_data  = '0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata   = 8'h00;   // [7:0] record_byte
	logic             s_tuser   = 1'b0;    // [0] record_start
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [15:0]      m_tdata;             // [7:0] out_byte, [8] record_ok, [11:9] error_code
	logic [1:0]       m_tuser;             // [1:0] region
	logic             m_tlast;             // record_done

	// shadow copy of the configuration registers, reset values
	logic             kind_sh = 1'b0;
	logic [7:0]       version_sh = 8'd6;
	logic [POS_W-1:0] size_sh = 13'd36;

	// shadow copy of the record walk
	logic [POS_W-1:0] rec_pos = '0;
	logic [31:0]      rec_crc = CRC_INIT;
	err_t             rec_err = ERR_NONE;
	logic [7:0]       len_low = 8'h00;

	res_t awaited_verdicts[$];
	int   bytes_sent = 0;
	int   mismatches = 0;
	int   quiet_cycles = 0;
	bit   steady = 1'b0;   // no idling on either side while set

	crc32_framed_record_checker #(
		.NAME_BYTES(NAME_LEN),
		.MAX_PAYLOAD_BYTES(PAYLOAD_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	// reflected crc-32, one byte
	function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// payload size as the block uses it: 0 counts as 1, big values saturate
	function automatic int unsigned clamped_payload();
		if (size_sh == 0)
			return 1;
		if (size_sh > PAYLOAD_CAP)
			return PAYLOAD_CAP;
		return size_sh;
	endfunction

	function automatic int unsigned record_length();
		return HEADER_BYTES + (kind_sh ? NAME_LEN : 0) + clamped_payload() + 4;
	endfunction

	// only the first error of a record is kept
	function automatic void note_error(input err_t e);
		if (rec_err == ERR_NONE)
			rec_err = e;
	endfunction

	function automatic void clear_walk();
		rec_pos = '0;
		rec_crc = CRC_INIT;
		rec_err = ERR_NONE;
	endfunction

	// verdict for one accepted record byte; advances the shadow walk
	function automatic res_t predict_checked_byte(input logic [7:0] b, input logic start);
		int unsigned pay, name_len, total, pos, k;
		logic [31:0] magic, fin;
		res_t r;
		r = '0;
		pay = clamped_payload();
		name_len = kind_sh ? NAME_LEN : 0;
		total = record_length();
		// a start marker always resynchronizes to position 0
		if (start)
			clear_walk();
		pos = rec_pos;
		// at or past the last byte: treat as the final trailer byte
		if (pos >= total - 1) begin
			pos = total - 1;
			r.record_done = 1'b1;
		end
		if (pos < HEADER_BYTES)
			r.region = REG_HEADER;
		else if (pos < HEADER_BYTES + name_len)
			r.region = REG_NAME;
		else if (pos < total - 4)
			r.region = REG_PAYLOAD;
		else
			r.region = REG_CRC;

		if (r.region == REG_HEADER) begin
			if (pos < 4) begin
				magic = kind_sh ? MAGIC_PRESET : MAGIC_CURRENT;
				if (b != magic[8*pos +: 8])
					note_error(ERR_MAGIC);
			end else if (pos == 4) begin
				if (b != version_sh)
					note_error(ERR_VERSION);
			end else if (pos == 5) begin
				// kind byte only matters for preset records
				if (kind_sh && b != 8'd1)
					note_error(ERR_KIND);
			end else if (pos == 6) begin
				len_low = b;
			end else if ({b, len_low} != pay) begin
				note_error(ERR_LENGTH);
			end
		end else if (r.region == REG_NAME) begin
			if (!(b == 8'h20 || b == 8'h2D || b == 8'h5F ||
			      (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h30 && b <= 8'h39)))
				note_error(ERR_NAME);
		end

		if (r.region != REG_CRC) begin
			rec_crc = crc32_step(rec_crc, b);
		end else begin
			fin = rec_crc ^ CRC_INIT;
			k = (pos - (total - 4)) & 3;
			if (b != fin[8*k +: 8])
				note_error(ERR_CRC);
		end

		if (r.record_done) begin
			r.error_code = rec_err;
			r.record_ok = (rec_err == ERR_NONE);
			clear_walk();
		end else begin
			rec_pos = pos + 1;
		end
		r.out_byte = b;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers, all entered and left at a falling edge
	// ---------------------------------------------------------------

	// one record byte request; tvalid stays high afterwards unless the next call idles
	task automatic send_byte(input logic [7:0] b, input logic start);
		while (!steady && $urandom_range(99) < STALL_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= start;
		do
			@(posedge clk);
		while (!s_tready);
		awaited_verdicts.push_back(predict_checked_byte(b, start));
		bytes_sent++;
		@(negedge clk);
	endtask

	// hold the sender until every verdict is back, then let the pipeline empty
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (awaited_verdicts.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input cfg_index_t idx, input logic [POS_W-1:0] value);
		wait_results_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_RECORD_KIND:    kind_sh = value[0];
			CFG_SCHEMA_VERSION: version_sh = value[7:0];
			CFG_PAYLOAD_SIZE:   size_sh = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// builds a record for the current settings: correct unless flip_at names a byte
	// to damage; stop_at cuts the record short (negative sends all of it)
	task automatic send_record(input bit marker, input int flip_at, input int stop_at);
		logic [7:0]  rec[$];
		logic [31:0] magic, crc;
		int unsigned pay;
		int n;
		pay = clamped_payload();
		magic = kind_sh ? MAGIC_PRESET : MAGIC_CURRENT;
		for (int i = 0; i < 4; i++)
			rec.push_back(magic[8*i +: 8]);
		rec.push_back(version_sh);
		rec.push_back(kind_sh ? 8'd1 : 8'($urandom_range(255)));
		rec.push_back(pay[7:0]);
		rec.push_back(pay[15:8]);
		if (kind_sh)
			for (int i = 0; i < NAME_LEN; i++)
				rec.push_back(NAME_CHARS[$urandom_range(NAME_CHARS.len() - 1)]);
		for (int i = 0; i < pay; i++)
			rec.push_back(8'($urandom_range(255)));
		crc = CRC_INIT;
		foreach (rec[i])
			crc = crc32_step(crc, rec[i]);
		crc ^= CRC_INIT;
		for (int i = 0; i < 4; i++)
			rec.push_back(crc[8*i +: 8]);
		if (flip_at >= 0 && flip_at < rec.size())
			rec[flip_at] ^= 8'($urandom_range(1, 255));
		n = (stop_at >= 0 && stop_at < rec.size()) ? stop_at : rec.size();
		for (int i = 0; i < n; i++)
			send_byte(rec[i], marker && i == 0);
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// smallest record (size 0 used as 1), top version, then a garbage
	// record without a marker that must start right after the verdict
	task automatic test_min_payload_and_restart();
		cfg_write(CFG_RECORD_KIND, 13'd0);
		cfg_write(CFG_SCHEMA_VERSION, 13'd255);
		cfg_write(CFG_PAYLOAD_SIZE, 13'd0);
		send_record(1'b1, -1, -1);
		repeat (13) send_byte(8'hFF, 1'b0);
	endtask

	// a record cut off early, then the start marker resynchronizes
	task automatic test_start_marker_resync();
		send_record(1'b1, -1, 5);
		send_record(1'b1, -1, -1);
	endtask

	// preset record with a name, then one with a bad kind byte and no marker
	task automatic test_preset_record();
		cfg_write(CFG_RECORD_KIND, 13'd1);
		cfg_write(CFG_SCHEMA_VERSION, 13'd6);
		cfg_write(CFG_PAYLOAD_SIZE, 13'd1);
		send_record(1'b1, -1, -1);
		send_record(1'b0, 5, -1);
	endtask

	// payload size shrunk under a record in flight: next byte ends it as
	// the last trailer byte
	task automatic test_midrecord_config();
		cfg_write(CFG_RECORD_KIND, 13'd0);
		cfg_write(CFG_SCHEMA_VERSION, 13'd0);
		cfg_write(CFG_PAYLOAD_SIZE, 13'd4096);
		send_record(1'b1, -1, 12);
		cfg_write(CFG_PAYLOAD_SIZE, 13'd1);
		send_byte(8'($urandom_range(255)), 1'b0);
		send_record(1'b0, -1, -1);
	endtask

	// all-ones size saturates to the largest payload: a long flat-out stretch
	// of such a record, then the size drops and the next byte gives the verdict
	task automatic test_payload_clamp_high();
		cfg_write(CFG_PAYLOAD_SIZE, 13'h1FFF);
		steady = 1'b1;
		send_record(1'b1, -1, 150);
		steady = 1'b0;
		cfg_write(CFG_PAYLOAD_SIZE, 13'd1);
		send_byte(8'($urandom_range(255)), 1'b0);
	endtask

	task automatic random_config();
		cfg_write(CFG_RECORD_KIND, 13'($urandom_range(8191)));
		cfg_write(CFG_SCHEMA_VERSION,
			($urandom_range(1) != 0) ? 13'd6 : 13'($urandom_range(8191)));
		cfg_write(CFG_PAYLOAD_SIZE, ($urandom_range(9) != 0) ?
			13'($urandom_range(0, 24)) : 13'($urandom_range(25, 64)));
	endtask

	// mostly well-formed records with random content, some damaged,
	// some cut short, plus bursts of noise
	task automatic test_random_traffic();
		int first, pick;
		first = bytes_sent;
		random_config();
		while (bytes_sent - first < 480) begin
			if ($urandom_range(99) < 12)
				random_config();
			pick = $urandom_range(99);
			if (pick < 70)
				send_record($urandom_range(99) < 75,
					($urandom_range(99) < 30) ? $urandom_range(record_length() - 1) : -1, -1);
			else if (pick < 85)
				send_record(1'b1, -1, $urandom_range(1, 20));
			else
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom_range(255)), $urandom_range(99) < 20);
		end
	endtask

	// ---------------------------------------------------------------
	// result side
	// ---------------------------------------------------------------

	// downstream backpressure
	always @(negedge clk)
		m_tready <= steady || ($urandom_range(99) >= STALL_PCT);

	// compare every verdict request with the oldest prediction
	always @(posedge clk) begin
		res_t got, want;
		if (m_tvalid && m_tready) begin
			got.out_byte    = m_tdata[7:0];
			got.region      = region_t'(m_tuser);
			got.record_done = m_tlast;
			got.record_ok   = m_tdata[8];
			got.error_code  = err_t'(m_tdata[11:9]);
			if (awaited_verdicts.size() == 0) begin
				$error("unexpected result request, out_byte %0h", got.out_byte);
				mismatches++;
			end else begin
				want = awaited_verdicts.pop_front();
				if (got.out_byte !== want.out_byte) begin
					$error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
					mismatches++;
				end
				if (got.region !== want.region) begin
					$error("region: expected %0d, got %0d", want.region, got.region);
					mismatches++;
				end
				if (got.record_done !== want.record_done) begin
					$error("record_done: expected %0d, got %0d",
						want.record_done, got.record_done);
					mismatches++;
				end
				if (got.record_ok !== want.record_ok) begin
					$error("record_ok: expected %0d, got %0d", want.record_ok, got.record_ok);
					mismatches++;
				end
				if (got.error_code !== want.error_code) begin
					$error("error_code: expected %0d, got %0d",
						want.error_code, got.error_code);
					mismatches++;
				end
			end
		end
	end

	// stall detector: any request on any channel counts as progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_min_payload_and_restart();
		test_start_marker_resync();
		test_preset_record();
		test_midrecord_config();
		test_payload_clamp_high();
		test_random_traffic();

		// let the last verdicts come back, then a few spare cycles
		s_tvalid <= 1'b0;
		while (awaited_verdicts.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
